// ----- rtl/core/pte_pkg.sv -----
// Shared types, constants and coding functions of the POCSAG transmission encoder.
package pte_pkg;

    localparam int PREAMBLE_WORDS = 18;
    localparam int BATCH_WORDS    = 16;

    localparam int POS_W = $clog2(BATCH_WORDS);
    localparam int CNT_W = ($clog2(PREAMBLE_WORDS) > 4) ? $clog2(PREAMBLE_WORDS) : 4;
    localparam int GAP_W = 4;

    localparam logic [31:0] PREAMBLE_PATTERN = 32'hAAAA_AAAA;
    localparam logic [31:0] SYNC_WORD        = 32'h7CD2_15D8;
    localparam logic [31:0] IDLE_WORD        = 32'h7A89_C197;
    localparam logic [10:0] BCH_POLY         = 11'h769;

    // action codes of an input transaction
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_CHAR  = 2'd1;
    localparam logic [1:0] ACT_END   = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [20:0] address;
        logic [1:0]  function_bits;
        logic        numeric_mode;
        logic [7:0]  char_code;
    } t_in_item;

    typedef struct packed {
        logic [31:0] codeword;
        logic        last;
    } t_out_item;

    typedef enum logic [1:0] {
        CMD_START,
        CMD_MSG,
        CMD_END
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op          op;
        logic             has_word;
        logic [20:0]      data;
        logic [GAP_W-1:0] gap;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_HEAD,
        ST_PREAMBLE,
        ST_SYNC_START,
        ST_GAP,
        ST_ADDR,
        ST_MSG_SYNC,
        ST_PAD
    } t_back_state;

    typedef enum logic [1:0] {
        WSEL_PREAMBLE,
        WSEL_SYNC,
        WSEL_IDLE,
        WSEL_CODE
    } t_word_sel;

    typedef logic [9:0] t_bch_cols [21];

    // remainder of each single data bit, worked out at elaboration
    function automatic t_bch_cols f_bch_cols();
        t_bch_cols   cols;
        logic [30:0] r;
        for (int i = 0; i < 21; i++) begin
            r = 31'(1) << (i + 10);
            for (int k = 30; k >= 10; k--) begin
                if (r[k]) begin
                    r = r ^ (31'(BCH_POLY) << (k - 10));
                end
            end
            cols[i] = r[9:0];
        end
        return cols;
    endfunction

    localparam t_bch_cols BCH_COLS = f_bch_cols();

    // BCH(31,21) check bits plus even parity; the code is linear so the
    // remainder is an XOR of per-bit columns
    function automatic logic [31:0] f_bch_word(input logic [20:0] data);
        logic [9:0]  rem;
        logic [30:0] full;
        rem = '0;
        for (int i = 0; i < 21; i++) begin
            if (data[i]) begin
                rem = rem ^ BCH_COLS[i];
            end
        end
        full = {data, rem};
        return {full, ^full};
    endfunction

    function automatic logic [3:0] f_digit_code(input logic [7:0] c);
        logic [3:0] d;
        case (c)
            8'h30:        d = 4'h0;
            8'h31:        d = 4'h8;
            8'h32:        d = 4'h4;
            8'h33:        d = 4'hC;
            8'h34:        d = 4'h2;
            8'h35:        d = 4'hA;
            8'h36:        d = 4'h6;
            8'h37:        d = 4'hE;
            8'h38:        d = 4'h1;
            8'h39:        d = 4'h9;
            8'h20:        d = 4'h3;  // space
            8'h75, 8'h55: d = 4'hD;  // u, U
            8'h2D, 8'h5F: d = 4'hB;  // dash, underscore
            8'h28, 8'h5B: d = 4'hF;  // opening brackets
            8'h29, 8'h5D: d = 4'h7;  // closing brackets
            default:      d = 4'h5;
        endcase
        return d;
    endfunction

endpackage

// ----- rtl/core/pte_if.sv -----
// Valid/ready stream interfaces for the input and output channels.
interface pte_in_if;
    import pte_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface pte_out_if;
    import pte_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/pocsag_transmission_encoder.sv -----
// Top level of the POCSAG transmission encoder.
//
// Input channel i_in carries one transaction per action: start (address,
// function bits, coding mode), character (one byte) or end of message.
// Output channel o_out carries one 32-bit codeword per transaction; last
// marks the final codeword caused by one input transaction.
// A start gives the preamble words, a sync word, idle words up to the
// address frame and the address word. A character gives nothing or a
// message word, an end the flushed word if bits are pending; either is
// followed by a sync at a batch boundary; an end's idles close the batch.
// The front end takes one input transaction per cycle while the two-entry
// command queue has room; it packs character bits in place, so characters
// that fill no word never reach the queue.
// The back end emits one codeword per cycle while a command is queued and
// the receiver keeps up; a transaction passes the queue and the output
// register. Output rate is set by the back end's single word per cycle.
// When the receiver stalls, the output register holds its codeword, the back
// end and the queue stop, and i_in.ready drops once the queue is full.
// Synchronous reset clears the bit accumulator, batch position, coding mode,
// queue and output valid; no transaction is pending afterward.
module pocsag_transmission_encoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pte_in_if.sink    i_in,
    pte_out_if.source o_out
);
    import pte_pkg::*;

    logic queue_full;
    logic push;
    t_cmd cmd;
    logic pop;
    logic head_valid;
    t_cmd head;

    // classify input and pack message bits
    pte_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_cmd        (cmd)
    );

    // decouples front and back so each can stall on its own
    pte_cmd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_cmd        (cmd),
        .o_full       (queue_full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    // codeword sequencing, BCH encoding and batch sync insertion
    pte_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule

// ----- rtl/core/pte_front.sv -----
// Front end: accepts input transactions, packs message bits, issues commands.
module pte_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pte_in_if.sink        i_in,
    input  logic          i_queue_full,
    output logic          o_push,
    output pte_pkg::t_cmd o_cmd
);
    import pte_pkg::*;

    logic [19:0] r_acc, n_acc;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_numeric, n_numeric;

    logic        accept;
    logic [6:0]  nb_text;
    logic [6:0]  nb;
    logic [4:0]  nbits;
    logic [4:0]  total;
    logic [2:0]  sh;
    logic [26:0] merged;
    logic [26:0] mask;

    // no transaction is taken while reset is held
    assign i_in.ready = i_rst_n && !i_queue_full;
    assign accept     = i_in.valid && i_in.ready;

    // text bits go LSB first, so the first bit sent is the top of nb
    always_comb begin
        for (int i = 0; i < 7; i++) begin
            nb_text[6 - i] = i_in.payload.char_code[i];
        end
    end

    assign nb     = r_numeric ? {3'b000, f_digit_code(i_in.payload.char_code)} : nb_text;
    assign nbits  = r_numeric ? 5'd4 : 5'd7;
    assign total  = r_cnt + nbits;
    assign sh     = 3'(total - 5'd20);
    assign merged = (27'(r_acc) << nbits) | 27'(nb);
    assign mask   = (27'd1 << sh) - 27'd1;

    always_comb begin
        n_acc     = r_acc;
        n_cnt     = r_cnt;
        n_numeric = r_numeric;
        o_push    = 1'b0;
        o_cmd     = '{op: CMD_MSG, has_word: 1'b1, data: '0, gap: '0};
        if (accept) begin
            case (i_in.payload.action)
                ACT_START: begin
                    o_push    = 1'b1;
                    o_cmd.op  = CMD_START;
                    o_cmd.data = {1'b0, i_in.payload.address[20:3],
                                  i_in.payload.function_bits};
                    o_cmd.gap = {i_in.payload.address[2:0], 1'b0};
                    n_acc     = '0;
                    n_cnt     = '0;
                    n_numeric = i_in.payload.numeric_mode;
                end
                ACT_CHAR: begin
                    if (total >= 5'd20) begin
                        o_push     = 1'b1;
                        o_cmd.data = {1'b1, 20'(merged >> sh)};
                        n_acc      = 20'(merged & mask);
                        n_cnt      = 5'(sh);
                    end else begin
                        n_acc = merged[19:0];
                        n_cnt = total;
                    end
                end
                ACT_END: begin
                    o_push         = 1'b1;
                    o_cmd.op       = CMD_END;
                    o_cmd.has_word = (r_cnt != 5'd0);
                    o_cmd.data     = {1'b1, r_acc << (5'd20 - r_cnt)};
                    n_acc          = '0;
                    n_cnt          = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_cnt     <= '0;
            r_numeric <= 1'b0;
        end else begin
            r_acc     <= n_acc;
            r_cnt     <= n_cnt;
            r_numeric <= n_numeric;
        end
    end

endmodule

// ----- rtl/core/pte_cmd_queue.sv -----
// Two-entry command queue between front and back end.
module pte_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pte_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_head_valid,
    output pte_pkg::t_cmd o_head
);
    import pte_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full       = (r_count == 2'd2);
    assign o_head_valid = (r_count != 2'd0);
    assign o_head       = r_mem[r_rd_ptr];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/core/pte_back.sv -----
// Back end: expands commands into codewords, tracks batch position, drives output.
module pte_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_head_valid,
    input  pte_pkg::t_cmd i_head,
    output logic          o_pop,
    pte_out_if.source     o_out
);
    import pte_pkg::*;

    localparam logic [CNT_W-1:0] PRE_LAST = CNT_W'(PREAMBLE_WORDS - 1);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(BATCH_WORDS - 1);

    t_back_state      r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_out_valid;
    t_out_item        r_out;

    logic      out_free;
    logic      step;
    logic      pos_full;
    logic      pop_cmd;
    logic      last;
    t_word_sel sel;
    logic [31:0] word;

    assign out_free = !r_out_valid || o_out.ready;
    assign step     = i_head_valid && out_free;
    assign pos_full = (r_pos == POS_LAST);
    assign o_pop    = step && pop_cmd;

    // next state, counters
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_pos   = r_pos;
        case (r_state)
            ST_HEAD: begin
                case (i_head.op)
                    CMD_START: begin
                        n_cnt   = CNT_W'(1);
                        n_state = (PREAMBLE_WORDS == 1) ? ST_SYNC_START : ST_PREAMBLE;
                    end
                    CMD_MSG: begin
                        if (pos_full) begin
                            n_pos   = '0;
                            n_state = ST_MSG_SYNC;
                        end else begin
                            n_pos = r_pos + POS_W'(1);
                        end
                    end
                    CMD_END: begin
                        if (pos_full) begin
                            n_pos   = '0;
                            n_state = i_head.has_word ? ST_MSG_SYNC : ST_HEAD;
                        end else begin
                            n_pos   = r_pos + POS_W'(1);
                            n_state = ST_PAD;
                        end
                    end
                    default: n_state = ST_HEAD;
                endcase
            end
            ST_PREAMBLE: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == PRE_LAST) begin
                    n_state = ST_SYNC_START;
                end
            end
            ST_SYNC_START: begin
                n_cnt   = '0;
                n_state = (i_head.gap == '0) ? ST_ADDR : ST_GAP;
            end
            ST_GAP: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (n_cnt == CNT_W'(i_head.gap)) begin
                    n_state = ST_ADDR;
                end
            end
            ST_ADDR: begin
                n_pos   = POS_W'(i_head.gap) + POS_W'(1);
                n_state = ST_HEAD;
            end
            ST_MSG_SYNC: begin
                n_state = (i_head.op == CMD_END) ? ST_PAD : ST_HEAD;
            end
            ST_PAD: begin
                if (pos_full) begin
                    n_pos   = '0;
                    n_state = ST_HEAD;
                end else begin
                    n_pos = r_pos + POS_W'(1);
                end
            end
            default: n_state = ST_HEAD;
        endcase
    end

    // word select, last flag, command retire
    always_comb begin
        sel     = WSEL_IDLE;
        last    = 1'b0;
        pop_cmd = 1'b0;
        case (r_state)
            ST_HEAD: begin
                case (i_head.op)
                    CMD_START: sel = WSEL_PREAMBLE;
                    CMD_MSG: begin
                        sel     = WSEL_CODE;
                        last    = !pos_full;
                        pop_cmd = !pos_full;
                    end
                    CMD_END: begin
                        sel     = i_head.has_word ? WSEL_CODE : WSEL_IDLE;
                        last    = !i_head.has_word && pos_full;
                        pop_cmd = !i_head.has_word && pos_full;
                    end
                    default: begin
                        pop_cmd = 1'b1;
                    end
                endcase
            end
            ST_PREAMBLE:   sel = WSEL_PREAMBLE;
            ST_SYNC_START: sel = WSEL_SYNC;
            ST_GAP:        sel = WSEL_IDLE;
            ST_ADDR: begin
                sel     = WSEL_CODE;
                last    = 1'b1;
                pop_cmd = 1'b1;
            end
            ST_MSG_SYNC: begin
                sel     = WSEL_SYNC;
                last    = (i_head.op != CMD_END);
                pop_cmd = (i_head.op != CMD_END);
            end
            ST_PAD: begin
                sel     = WSEL_IDLE;
                last    = pos_full;
                pop_cmd = pos_full;
            end
            default: begin
                sel = WSEL_IDLE;
            end
        endcase
    end

    always_comb begin
        case (sel)
            WSEL_PREAMBLE: word = PREAMBLE_PATTERN;
            WSEL_SYNC:     word = SYNC_WORD;
            WSEL_IDLE:     word = IDLE_WORD;
            WSEL_CODE:     word = f_bch_word(i_head.data);
            default:       word = IDLE_WORD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_HEAD;
            r_cnt       <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (step) begin
                r_state <= n_state;
                r_cnt   <= n_cnt;
                r_pos   <= n_pos;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= '{codeword: word, last: last};
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

endmodule

// ----- rtl/core/pte_checker.sv -----
// Port-level checker for the POCSAG transmission encoder, bound to the top level.
module pte_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic [1:0]  i_in_action,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_codeword,
    input logic        i_out_last
);
    import pte_pkg::*;

    // output register comes up empty out of reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // a start always yields valid output once through the queue and output register
    a_start_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_action == ACT_START) |=> ##1 i_out_valid)
        else $error("no codeword after start transaction");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> ($stable(i_out_codeword) && $stable(i_out_last)))
        else $error("output payload changed while stalled");

endmodule

bind pocsag_transmission_encoder pte_checker u_pte_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_action    (i_in.payload.action),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_codeword (o_out.payload.codeword),
    .i_out_last     (o_out.payload.last)
);

// ----- dv/pocsag_transmission_encoder_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the POCSAG transmission encoder.
module pocsag_transmission_encoder_test;
    import pte_pkg::*;

    // Action code the block must ignore.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS   = 270;
    // The last transactions run with both sides at full speed.
    localparam int CALM_ITEMS     = 40;
    // Worst quiet stretch of a correct run: the longest source gap on top of the
    // longest sink stall plus the pipeline registers. Taken many times.
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 20;

    // Low ten bits of the BCH(31,21) generator; x^10 is implied.
    localparam logic [9:0] BCH_TAPS = BCH_POLY[9:0];

    logic i_clk;
    logic i_rst_n;

    pte_in_if  in_bus ();
    pte_out_if out_bus ();

    pocsag_transmission_encoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // Digits first, then the non-digit characters with a numeric code.
    string numeric_charset = "0123456789 uU-_([)]";

    t_in_item  pending_items[$];   // transactions waiting for the driver
    t_out_item expected_words[$];  // codewords predicted, not yet seen
    logic [31:0] word_burst[$];    // codewords of the transaction being encoded

    // Shadow encoder state.
    logic [19:0] msg_bits       = '0;
    int          msg_nbits      = 0;
    int          batch_pos      = 0;
    logic        numeric_coding = 1'b0;

    int total_items   = 0;
    int n_accepted    = 0;
    int n_starts      = 0;
    int n_ends        = 0;
    int n_checked     = 0;
    int n_mismatch    = 0;
    int src_hold      = 0;
    int sink_hold     = 0;
    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int idle_cycles   = 0;

    //------------------------------------------------------------------
    // Clock and known values on every input from time zero
    //------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        in_bus.valid   = 1'b0;
        in_bus.payload = '0;
        out_bus.ready  = 1'b0;
    end

    //------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------
    // Serial division by the generator, then even parity over 31 bits.
    function automatic logic [31:0] bch_codeword(input logic [20:0] data);
        logic [9:0]  rem;
        logic        fb;
        logic [30:0] body;
        rem = '0;
        for (int i = 20; i >= 0; i--) begin
            fb  = data[i] ^ rem[9];
            rem = {rem[8:0], 1'b0};
            if (fb) begin
                rem = rem ^ BCH_TAPS;
            end
        end
        body = {data, rem};
        return {body, ^body};
    endfunction

    function automatic logic [3:0] numeric_nibble(input logic [7:0] c);
        logic [3:0] digit_nibbles [10];
        digit_nibbles = '{4'h0, 4'h8, 4'h4, 4'hC, 4'h2, 4'hA, 4'h6, 4'hE, 4'h1, 4'h9};
        if (c >= "0" && c <= "9") begin
            return digit_nibbles[c - "0"];
        end
        case (c)
            " ":      return 4'h3;
            "u", "U": return 4'hD;
            "-", "_": return 4'hB;
            "(", "[": return 4'hF;
            ")", "]": return 4'h7;
            default:  return 4'h5;
        endcase
    endfunction

    function automatic void emit_word(input logic [31:0] w);
        word_burst.push_back(w);
    endfunction

    // Message word with the flag bit; a sync word closes a full batch.
    function automatic void emit_message(input logic [19:0] data20);
        emit_word(bch_codeword({1'b1, data20}));
        batch_pos++;
        if (batch_pos >= BATCH_WORDS) begin
            emit_word(SYNC_WORD);
            batch_pos = 0;
        end
    endfunction

    function automatic void feed_bit(input logic b);
        msg_bits = {msg_bits[18:0], b};
        msg_nbits++;
        if (msg_nbits >= 20) begin
            emit_message(msg_bits);
            msg_bits  = '0;
            msg_nbits = 0;
        end
    endfunction

    // Works out every codeword one accepted transaction causes.
    function automatic void encode_transaction(input t_in_item it);
        int gap;
        logic [3:0] nib;
        word_burst.delete();
        case (it.action)
            ACT_START: begin
                gap = int'(it.address[2:0]) * 2;
                for (int i = 0; i < PREAMBLE_WORDS; i++) begin
                    emit_word(PREAMBLE_PATTERN);
                end
                emit_word(SYNC_WORD);
                for (int i = 0; i < gap; i++) begin
                    emit_word(IDLE_WORD);
                end
                emit_word(bch_codeword({1'b0, it.address[20:3], it.function_bits}));
                batch_pos      = gap + 1;
                msg_bits       = '0;   // a partial word is dropped
                msg_nbits      = 0;
                numeric_coding = it.numeric_mode;
                n_starts++;
            end
            ACT_CHAR: begin
                if (numeric_coding) begin
                    nib = numeric_nibble(it.char_code);
                    for (int i = 3; i >= 0; i--) begin
                        feed_bit(nib[i]);
                    end
                end else begin
                    for (int i = 0; i < 7; i++) begin
                        feed_bit(it.char_code[i]);
                    end
                end
            end
            ACT_END: begin
                if (msg_nbits > 0) begin
                    emit_message(msg_bits << (20 - msg_nbits));
                end
                msg_bits  = '0;
                msg_nbits = 0;
                emit_word(IDLE_WORD);
                batch_pos++;
                while (batch_pos < BATCH_WORDS) begin
                    emit_word(IDLE_WORD);
                    batch_pos++;
                end
                batch_pos = 0;
                n_ends++;
            end
            default: ;  // unused action: nothing happens
        endcase
        foreach (word_burst[i]) begin
            expected_words.push_back('{codeword: word_burst[i],
                                       last: (i == word_burst.size() - 1)});
        end
    endfunction

    //------------------------------------------------------------------
    // Helpers for stimulus and checking
    //------------------------------------------------------------------
    // Every field random, so each bit toggles whatever the action uses.
    function automatic t_in_item rand_item(input logic [1:0] act);
        t_in_item it;
        it.action        = act;
        it.address       = 21'($urandom);
        it.function_bits = 2'($urandom);
        it.numeric_mode  = 1'($urandom);
        it.char_code     = 8'($urandom);
        return it;
    endfunction

    // Mix of busy, lightly idle and heavily idle stretches.
    function automatic int pick_idle_pct();
        case ($urandom_range(0, 3))
            0, 1:    return 0;
            2:       return 15;
            default: return 50;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        n_mismatch++;
    endtask

    //------------------------------------------------------------------
    // Driver: pops pending transactions, idles in random bursts
    //------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
            src_hold       = 0;
            msg_bits       = '0;
            msg_nbits      = 0;
            batch_pos      = 0;
            numeric_coding = 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                encode_transaction(in_bus.payload);
                n_accepted++;
                if (n_accepted % 32 == 0) begin
                    src_idle_pct = pick_idle_pct();
                end
            end
            // Slot is free when nothing is offered or the offer just went.
            if (!in_bus.valid || in_bus.ready) begin
                if (src_hold == 0 && pending_items.size() >= CALM_ITEMS &&
                    $urandom_range(0, 99) < src_idle_pct) begin
                    src_hold = $urandom_range(1, 18);
                end
                if (src_hold > 0) begin
                    src_hold--;
                    in_bus.valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    in_bus.payload <= pending_items.pop_front();
                    in_bus.valid   <= 1'b1;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Monitor: checks each codeword against the oldest prediction
    //------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
            sink_hold = 0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                got = out_bus.payload;
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("unexpected codeword %h last %b",
                                              got.codeword, got.last));
                end else begin
                    want = expected_words.pop_front();
                    if (got.codeword !== want.codeword) begin
                        report_mismatch($sformatf("word %0d: codeword %h, predicted %h",
                                                  n_checked, got.codeword, want.codeword));
                    end
                    if (got.last !== want.last) begin
                        report_mismatch($sformatf("word %0d (%h): last %b, predicted %b",
                                                  n_checked, got.codeword, got.last,
                                                  want.last));
                    end
                    n_checked++;
                    if (n_checked % 64 == 0) begin
                        sink_stall_pct = pick_idle_pct();
                    end
                end
            end
            if (sink_hold == 0 && pending_items.size() >= CALM_ITEMS &&
                $urandom_range(0, 99) < sink_stall_pct) begin
                sink_hold = $urandom_range(1, 18);
            end
            if (sink_hold > 0) begin
                sink_hold--;
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    //------------------------------------------------------------------
    // Watchdog: too long without any transaction on either side
    //------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles, %0d codewords outstanding",
                     idle_cycles, expected_words.size());
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    //------------------------------------------------------------------
    // Stimulus, reset and end of run
    //------------------------------------------------------------------
    initial begin
        t_in_item it;
        int   n_random;
        int   kind;
        int   len;
        logic nmode;

        // Directed part.
        // Character and end before any start: state is used as reset left it.
        it = rand_item(ACT_CHAR);
        it.char_code = "A";
        pending_items.push_back(it);
        pending_items.push_back(rand_item(ACT_END));
        pending_items.push_back(rand_item(ACT_UNUSED));
        // Highest address: frame 7, so one batch slot is left after the address
        // word, and the end fills it with a single idle word.
        it = rand_item(ACT_START);
        it.address       = '1;
        it.function_bits = 2'b11;
        it.numeric_mode  = 1'b0;
        pending_items.push_back(it);
        pending_items.push_back(rand_item(ACT_END));
        // Lowest address in numeric coding; digits and every special character.
        it = rand_item(ACT_START);
        it.address       = '0;
        it.function_bits = 2'b00;
        it.numeric_mode  = 1'b1;
        pending_items.push_back(it);
        for (int i = 0; i < numeric_charset.len(); i++) begin
            it = rand_item(ACT_CHAR);
            it.char_code = numeric_charset[i];
            pending_items.push_back(it);
        end
        it = rand_item(ACT_CHAR);
        it.char_code = 8'hFF;   // no numeric meaning
        pending_items.push_back(it);
        // New start after the numeric characters, which fill whole words: nothing is pending.
        it = rand_item(ACT_START);
        it.address       = 21'd5;
        it.function_bits = 2'b01;
        it.numeric_mode  = 1'b0;
        pending_items.push_back(it);
        it = rand_item(ACT_CHAR);
        it.char_code = 8'h00;
        pending_items.push_back(it);
        it = rand_item(ACT_CHAR);
        it.char_code = 8'hFF;
        pending_items.push_back(it);
        pending_items.push_back(rand_item(ACT_END));
        // Flushed word fills the batch: sync, then a full batch of idles.
        it = rand_item(ACT_START);
        it.address      = 21'd7;
        it.numeric_mode = 1'b0;
        pending_items.push_back(it);
        it = rand_item(ACT_CHAR);
        it.char_code = 8'h7F;
        pending_items.push_back(it);
        pending_items.push_back(rand_item(ACT_END));

        // Random part: mostly complete messages, some cut short by a new
        // start, some stray characters and ends, some unused actions.
        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind <= 7) begin
                it    = rand_item(ACT_START);
                nmode = it.numeric_mode;
                pending_items.push_back(it);
                n_random++;
                // Occasional long message crosses batch boundaries.
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 64)
                                                  : $urandom_range(0, 12);
                repeat (len) begin
                    it = rand_item(ACT_CHAR);
                    if (nmode && $urandom_range(0, 3) != 0) begin
                        it.char_code = numeric_charset[$urandom_range(0,
                                                       numeric_charset.len() - 1)];
                    end
                    pending_items.push_back(it);
                    n_random++;
                end
                if (kind != 7) begin
                    pending_items.push_back(rand_item(ACT_END));
                    n_random++;
                end
            end else if (kind == 8) begin
                repeat ($urandom_range(1, 4)) begin
                    pending_items.push_back(rand_item($urandom_range(0, 1) ? ACT_CHAR
                                                                           : ACT_END));
                    n_random++;
                end
            end else begin
                pending_items.push_back(rand_item(ACT_UNUSED));
                n_random++;
            end
        end
        total_items = pending_items.size();

        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted != total_items) @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
        // Catch any codeword beyond the predicted ones.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d input transactions: %0d starts, %0d ends, rest characters or unused",
                 total_items, n_starts, n_ends);
        $display("Compared %0d codewords, %0d mismatches", n_checked, n_mismatch);
        if (n_mismatch == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
